@@ rtl/msadpcm_pkg.sv @@
// msadpcm_pkg: constants, tables and types for the ms adpcm nibble decoder
// no dependencies; used by ms_adpcm_nibble_decoder_top
package msadpcm_pkg;

   localparam int CHANNELS         = 2;
   localparam int MAX_CUSTOM_PAIRS = 7;
   localparam int NUM_STD_PAIRS    = 7;
   localparam int NUM_PAIR_REGS    = 7;
   localparam int NUM_CSR          = NUM_PAIR_REGS + 1;
   localparam int CH_W             = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CSR_IDX_W        = $clog2(NUM_CSR);
   localparam int ADDR_W           = CSR_IDX_W + 2;
   localparam int PAIR_IDX_W       = $clog2(NUM_PAIR_REGS);
   localparam int CNT_W            = 3;
   localparam int MIN_STEP         = 16;

   // effective custom count limit
   localparam int CNT_LIMIT = (MAX_CUSTOM_PAIRS < NUM_PAIR_REGS) ? MAX_CUSTOM_PAIRS
                                                                   : NUM_PAIR_REGS;

   // item kinds
   localparam logic MODE_HEADER = 1'b0;
   localparam logic MODE_DATA   = 1'b1;

   // register map indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CUSTOM_COUNT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_PAIR_BASE    = CSR_IDX_W'(1);

   typedef logic signed [15:0] sample_type;

   typedef struct packed {
      logic       mode;
      logic       channel;
      logic [7:0] predictor_index;
      sample_type initial_step;
      sample_type older_sample;
      sample_type newer_sample;
      logic [7:0] data_byte;
   } item_type;

   // standard coefficient pairs, first coefficient
   function automatic sample_type std_coef_first(input logic [2:0] idx);
      sample_type c;
      case (idx)
         3'd0:    c = 16'sd256;
         3'd1:    c = 16'sd512;
         3'd2:    c = 16'sd0;
         3'd3:    c = 16'sd192;
         3'd4:    c = 16'sd240;
         3'd5:    c = 16'sd460;
         3'd6:    c = 16'sd392;
         default: c = 16'sd0;
      endcase
      return c;
   endfunction

   // standard coefficient pairs, second coefficient
   function automatic sample_type std_coef_second(input logic [2:0] idx);
      sample_type c;
      case (idx)
         3'd0:    c = 16'sd0;
         3'd1:    c = -16'sd256;
         3'd2:    c = 16'sd0;
         3'd3:    c = 16'sd64;
         3'd4:    c = 16'sd0;
         3'd5:    c = -16'sd208;
         3'd6:    c = -16'sd232;
         default: c = 16'sd0;
      endcase
      return c;
   endfunction

   // step adaptation factors in 1/256 units
   function automatic logic [9:0] adapt_factor(input logic [3:0] nib);
      logic [9:0] f;
      case (nib)
         4'd4, 4'd12: f = 10'd307;
         4'd5, 4'd11: f = 10'd409;
         4'd6, 4'd10: f = 10'd512;
         4'd7, 4'd9:  f = 10'd614;
         4'd8:        f = 10'd768;
         default:     f = 10'd230;
      endcase
      return f;
   endfunction

endpackage

@@ rtl/ms_adpcm_nibble_decoder_top.sv @@
// ms_adpcm_nibble_decoder_top: 4-bit ms adpcm to 16-bit pcm decoder with apb-style csr port
// depends on msadpcm_pkg
//
// usage
//   req channel: one transfer per item. mode header loads one channel's history,
//   step size and coefficient pair; mode data carries one byte of two nibbles.
//   rsp channel: every item gives exactly two transfers, rsp_last high on the
//   second. a header returns the older then the newer history sample; a data
//   byte returns the high nibble decoded on channel 0, then the low nibble on
//   the last channel.
//   csr port: custom pair count at 0x00, coefficient pairs at 0x04..0x1c; pready
//   is tied high; the user writes them only while the decoder is idle (unenforced).
// timing
//   an item sits in the input register until both results are produced, since the
//   single shared decode path produces one sample a cycle while the output
//   register is free. each result goes from the input register to the output
//   register; a new item is not taken before the current one's second result, and
//   is taken in the cycle that second result is written to the output register.
// reset clears all channel state, csr registers and both valid flags.
// a stall on rsp holds the output register and then the input register;
// req_ready drops until space frees up.
module ms_adpcm_nibble_decoder_top (
   input  logic                                clock,
   input  logic                                reset,
   // input items
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic                                req_channel,
   input  logic [7:0]                          req_predictor_index,
   input  logic signed [15:0]                  req_initial_step,
   input  logic signed [15:0]                  req_older_sample,
   input  logic signed [15:0]                  req_newer_sample,
   input  logic [7:0]                          req_data_byte,
   // results
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [15:0]                  rsp_pcm_sample,
   output logic                                rsp_out_channel,
   output logic                                rsp_last,
   // csr port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [msadpcm_pkg::ADDR_W-1:0]      paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);

   localparam int PROD_W = 34;
   localparam int PRED_W = PROD_W - 8;
   localparam int SUM_W  = PRED_W + 1;
   localparam int SERR_W = 21;
   localparam int ADP_W  = 27;

   // csr registers
   logic [msadpcm_pkg::CNT_W-1:0] pair_count_ff;
   logic [31:0]                   coef_pair_ff [msadpcm_pkg::NUM_PAIR_REGS];
   logic [msadpcm_pkg::CSR_IDX_W-1:0] csr_idx;
   logic                          csr_wr;

   // channel state
   msadpcm_pkg::sample_type hist_newer_ff  [msadpcm_pkg::CHANNELS];
   msadpcm_pkg::sample_type hist_older_ff  [msadpcm_pkg::CHANNELS];
   msadpcm_pkg::sample_type coef_first_ff  [msadpcm_pkg::CHANNELS];
   msadpcm_pkg::sample_type coef_second_ff [msadpcm_pkg::CHANNELS];
   msadpcm_pkg::sample_type step_size_ff   [msadpcm_pkg::CHANNELS];

   // input register
   msadpcm_pkg::item_type item_ff;
   logic                  stage_valid_ff, stage_valid_in;
   logic                  phase_ff, phase_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   msadpcm_pkg::sample_type pcm_ff, pcm_in;
   logic                    out_ch_ff, out_ch_in;
   logic                    last_ff;

   logic out_free, fire, req_take;

   // decode path
   logic [msadpcm_pkg::CH_W-1:0] ch;
   logic [msadpcm_pkg::CH_W-1:0] hdr_ch;
   logic [3:0]                   nib;
   logic signed [4:0]            err;
   msadpcm_pkg::sample_type      hn, ho, cf, cs, st;
   logic signed [PROD_W-1:0]     prod, prod_rnd;
   logic signed [PRED_W-1:0]     pred;
   logic signed [SERR_W-1:0]     step_err;
   logic signed [SUM_W-1:0]      s_sum;
   msadpcm_pkg::sample_type      s_clamp;
   logic signed [ADP_W-1:0]      adp_prod, adp_rnd;
   msadpcm_pkg::sample_type      step_new;

   // coefficient selection for headers
   logic [msadpcm_pkg::CNT_W-1:0]      cnt_eff;
   logic [msadpcm_pkg::PAIR_IDX_W-1:0] pair_idx;
   logic                               use_custom, use_std;
   msadpcm_pkg::sample_type            sel_first, sel_second;

   // ---------------------------------------------------------------- csr
   assign pready  = 1'b1;
   assign csr_idx = paddr[msadpcm_pkg::ADDR_W-1:2];
   assign csr_wr  = psel & penable & pwrite;

   always_comb begin
      if (csr_idx == msadpcm_pkg::CSR_CUSTOM_COUNT) begin
         prdata = 32'(pair_count_ff);
      end else begin
         prdata = coef_pair_ff[msadpcm_pkg::PAIR_IDX_W'(csr_idx - msadpcm_pkg::CSR_PAIR_BASE)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_count_ff <= '0;
         for (int i = 0; i < msadpcm_pkg::NUM_PAIR_REGS; i++) begin
            coef_pair_ff[i] <= '0;
         end
      end else if (csr_wr) begin
         if (csr_idx == msadpcm_pkg::CSR_CUSTOM_COUNT) begin
            pair_count_ff <= pwdata[msadpcm_pkg::CNT_W-1:0];
         end else begin
            coef_pair_ff[msadpcm_pkg::PAIR_IDX_W'(csr_idx - msadpcm_pkg::CSR_PAIR_BASE)]
               <= pwdata;
         end
      end
   end

   // ---------------------------------------------------------------- handshake
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign fire      = stage_valid_ff & out_free;
   assign req_ready = ~stage_valid_ff | (phase_ff & out_free);
   assign req_take  = req_valid & req_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      phase_in       = phase_ff;
      if (fire) begin
         phase_in = ~phase_ff;
         if (phase_ff) begin
            stage_valid_in = 1'b0;
         end
      end
      if (req_take) begin
         stage_valid_in = 1'b1;
         phase_in       = 1'b0;
      end
      rsp_valid_in = fire | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         phase_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         phase_ff       <= phase_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.mode            <= req_mode;
         item_ff.channel         <= req_channel;
         item_ff.predictor_index <= req_predictor_index;
         item_ff.initial_step    <= req_initial_step;
         item_ff.older_sample    <= req_older_sample;
         item_ff.newer_sample    <= req_newer_sample;
         item_ff.data_byte       <= req_data_byte;
      end
      if (fire) begin
         pcm_ff    <= pcm_in;
         out_ch_ff <= out_ch_in;
         last_ff   <= phase_ff;
      end
   end

   // ---------------------------------------------------------------- decode
   always_comb begin
      // header channel beyond the build folds onto the last channel
      if (32'(item_ff.channel) >= msadpcm_pkg::CHANNELS) begin
         hdr_ch = msadpcm_pkg::CH_W'(msadpcm_pkg::CHANNELS - 1);
      end else begin
         hdr_ch = msadpcm_pkg::CH_W'(item_ff.channel);
      end

      if (item_ff.mode == msadpcm_pkg::MODE_HEADER) begin
         ch = hdr_ch;
      end else if (phase_ff) begin
         ch = msadpcm_pkg::CH_W'(msadpcm_pkg::CHANNELS - 1);
      end else begin
         ch = '0;
      end

      nib = phase_ff ? item_ff.data_byte[3:0] : item_ff.data_byte[7:4];
      err = $signed({nib[3], nib});

      hn = hist_newer_ff[ch];
      ho = hist_older_ff[ch];
      cf = coef_first_ff[ch];
      cs = coef_second_ff[ch];
      st = step_size_ff[ch];

      // prediction, divided by 256 toward zero
      prod     = PROD_W'(hn) * PROD_W'(cf) + PROD_W'(ho) * PROD_W'(cs);
      prod_rnd = prod + (prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
      pred     = prod_rnd[PROD_W-1:8];

      step_err = SERR_W'(st) * SERR_W'(err);
      s_sum    = SUM_W'(pred) + SUM_W'(step_err);
      if (s_sum > SUM_W'(32767)) begin
         s_clamp = 16'sh7fff;
      end else if (s_sum < -SUM_W'(32768)) begin
         s_clamp = -16'sh8000;
      end else begin
         s_clamp = s_sum[15:0];
      end

      // step adaptation, toward zero, wrapped to 16 bits then floored
      adp_prod = ADP_W'(st) * ADP_W'($signed({1'b0, msadpcm_pkg::adapt_factor(nib)}));
      adp_rnd  = adp_prod + (adp_prod[ADP_W-1] ? ADP_W'(255) : ADP_W'(0));
      step_new = adp_rnd[23:8];
      if (step_new < 16'(msadpcm_pkg::MIN_STEP)) begin
         step_new = 16'(msadpcm_pkg::MIN_STEP);
      end

      // coefficient pair for a header
      cnt_eff = (32'(pair_count_ff) > msadpcm_pkg::CNT_LIMIT)
                ? msadpcm_pkg::CNT_W'(msadpcm_pkg::CNT_LIMIT) : pair_count_ff;
      use_custom = 32'(item_ff.predictor_index) < 32'(cnt_eff);
      use_std    = 32'(item_ff.predictor_index) < msadpcm_pkg::NUM_STD_PAIRS;
      pair_idx   = item_ff.predictor_index[msadpcm_pkg::PAIR_IDX_W-1:0];
      if (use_custom) begin
         sel_first  = coef_pair_ff[pair_idx][15:0];
         sel_second = coef_pair_ff[pair_idx][31:16];
      end else begin
         sel_first  = msadpcm_pkg::std_coef_first(item_ff.predictor_index[2:0]);
         sel_second = msadpcm_pkg::std_coef_second(item_ff.predictor_index[2:0]);
      end

      if (item_ff.mode == msadpcm_pkg::MODE_HEADER) begin
         pcm_in = phase_ff ? item_ff.newer_sample : item_ff.older_sample;
      end else begin
         pcm_in = s_clamp;
      end
      out_ch_in = 1'(ch);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < msadpcm_pkg::CHANNELS; i++) begin
            hist_newer_ff[i]  <= '0;
            hist_older_ff[i]  <= '0;
            coef_first_ff[i]  <= '0;
            coef_second_ff[i] <= '0;
            step_size_ff[i]   <= '0;
         end
      end else if (fire) begin
         if (item_ff.mode == msadpcm_pkg::MODE_DATA) begin
            hist_older_ff[ch] <= hn;
            hist_newer_ff[ch] <= s_clamp;
            step_size_ff[ch]  <= step_new;
         end else if (!phase_ff) begin
            hist_older_ff[ch] <= item_ff.older_sample;
            hist_newer_ff[ch] <= item_ff.newer_sample;
            step_size_ff[ch]  <= item_ff.initial_step;
            if (use_custom || use_std) begin
               coef_first_ff[ch]  <= sel_first;
               coef_second_ff[ch] <= sel_second;
            end
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pcm_sample  = pcm_ff;
   assign rsp_out_channel = out_ch_ff;
   assign rsp_last        = last_ff;

endmodule

@@ bench/ms_adpcm_nibble_decoder_top_test.sv @@
// self-checking bench for ms_adpcm_nibble_decoder_top: directed and random items,
// with a decode scoreboard that predicts every pcm transfer
// depends on msadpcm_pkg and rtl/ms_adpcm_nibble_decoder_top.sv
`timescale 1ns / 1ps

module ms_adpcm_nibble_decoder_top_test;

   localparam int REG_PAIR_BASE   = int'(msadpcm_pkg::CSR_PAIR_BASE);
   localparam int PAIR_REGS       = msadpcm_pkg::NUM_PAIR_REGS;
   localparam int STD_PAIRS       = msadpcm_pkg::NUM_STD_PAIRS;
   localparam int NUM_CH          = msadpcm_pkg::CHANNELS;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_CYCLES    = 8;
   localparam int PHASE_ITEMS     = 225;
   localparam int CYCLE_LIMIT     = 300000;

   typedef struct {
      msadpcm_pkg::sample_type pcm;
      logic                    chan;
      logic                    last_flag;
   } pcm_entry_type;

   // keeps its own copy of channel state and registers, predicts two samples per item
   class pcm_scoreboard;
      msadpcm_pkg::sample_type chan_newer[NUM_CH];
      msadpcm_pkg::sample_type chan_older[NUM_CH];
      msadpcm_pkg::sample_type chan_coef_a[NUM_CH];
      msadpcm_pkg::sample_type chan_coef_b[NUM_CH];
      msadpcm_pkg::sample_type chan_step[NUM_CH];
      logic [2:0]   custom_count;
      logic [31:0]  pair_word[PAIR_REGS];
      int           std_a[STD_PAIRS];
      int           std_b[STD_PAIRS];
      int           adapt_gain[16];
      pcm_entry_type awaited_samples[$];
      int           errors;

      function new();
         for (int c = 0; c < NUM_CH; c++) begin
            chan_newer[c]  = '0;
            chan_older[c]  = '0;
            chan_coef_a[c] = '0;
            chan_coef_b[c] = '0;
            chan_step[c]   = '0;
         end
         for (int i = 0; i < PAIR_REGS; i++) pair_word[i] = '0;
         custom_count = '0;
         std_a = '{256, 512, 0, 192, 240, 460, 392};
         std_b = '{0, -256, 0, 64, 0, -208, -232};
         adapt_gain = '{230, 230, 230, 230, 307, 409, 512, 614,
                        768, 614, 512, 409, 307, 230, 230, 230};
         errors = 0;
      endfunction

      function void write_reg(int idx, logic [31:0] value);
         if (idx == int'(msadpcm_pkg::CSR_CUSTOM_COUNT)) begin
            custom_count = value[2:0];
         end else if (idx >= REG_PAIR_BASE && idx < REG_PAIR_BASE + PAIR_REGS) begin
            pair_word[idx - REG_PAIR_BASE] = value;
         end
      endfunction

      function msadpcm_pkg::sample_type decode(int ch, logic [3:0] nib);
         int         err;
         longint     prod;
         int         pred;
         int         s;
         int         d;
         msadpcm_pkg::sample_type wrapped;
         err  = nib[3] ? int'(nib) - 16 : int'(nib);
         prod = longint'(chan_newer[ch]) * longint'(chan_coef_a[ch])
              + longint'(chan_older[ch]) * longint'(chan_coef_b[ch]);
         pred = int'(prod / 256);
         s = pred + int'(chan_step[ch]) * err;
         if (s > 32767) s = 32767;
         if (s < -32768) s = -32768;
         // new step wraps to 16 bits before the floor is applied
         d = (int'(chan_step[ch]) * adapt_gain[nib]) / 256;
         wrapped = d[15:0];
         d = int'(wrapped);
         if (d < 16) d = 16;
         chan_step[ch]  = d[15:0];
         chan_older[ch] = chan_newer[ch];
         chan_newer[ch] = s[15:0];
         return s[15:0];
      endfunction

      function void take_item(msadpcm_pkg::item_type it);
         int            ch;
         int            idx;
         pcm_entry_type e0;
         pcm_entry_type e1;
         if (it.mode == msadpcm_pkg::MODE_HEADER) begin
            ch  = int'(it.channel);
            idx = int'(it.predictor_index);
            chan_older[ch] = it.older_sample;
            chan_newer[ch] = it.newer_sample;
            if (idx < int'(custom_count)) begin
               chan_coef_a[ch] = pair_word[idx][15:0];
               chan_coef_b[ch] = pair_word[idx][31:16];
            end else if (idx < STD_PAIRS) begin
               chan_coef_a[ch] = std_a[idx][15:0];
               chan_coef_b[ch] = std_b[idx][15:0];
            end
            chan_step[ch] = it.initial_step;
            e0 = '{chan_older[ch], it.channel, 1'b0};
            e1 = '{chan_newer[ch], it.channel, 1'b1};
         end else begin
            e0.pcm = decode(0, it.data_byte[7:4]);
            e0.chan = 1'b0;
            e0.last_flag = 1'b0;
            e1.pcm = decode(NUM_CH - 1, it.data_byte[3:0]);
            e1.chan = 1'(NUM_CH - 1);
            e1.last_flag = 1'b1;
         end
         awaited_samples.push_back(e0);
         awaited_samples.push_back(e1);
      endfunction

      function void check_sample(msadpcm_pkg::sample_type pcm, logic chan, logic last_flag);
         pcm_entry_type e;
         if (awaited_samples.size() == 0) begin
            $error("unexpected pcm transfer: sample %0d channel %0d last %0d",
                   pcm, chan, last_flag);
            errors++;
            return;
         end
         e = awaited_samples.pop_front();
         if (pcm !== e.pcm) begin
            $error("pcm_sample: expected %0d, actual %0d", e.pcm, pcm);
            errors++;
         end
         if (chan !== e.chan) begin
            $error("out_channel: expected %0d, actual %0d", e.chan, chan);
            errors++;
         end
         if (last_flag !== e.last_flag) begin
            $error("last: expected %0d, actual %0d", e.last_flag, last_flag);
            errors++;
         end
      endfunction

      function int pending();
         return awaited_samples.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_mode = msadpcm_pkg::MODE_HEADER;
   logic              req_channel = 1'b0;
   logic [7:0]        req_predictor_index = '0;
   logic signed [15:0] req_initial_step = '0;
   logic signed [15:0] req_older_sample = '0;
   logic signed [15:0] req_newer_sample = '0;
   logic [7:0]        req_data_byte = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic signed [15:0] rsp_pcm_sample;
   logic              rsp_out_channel;
   logic              rsp_last;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [msadpcm_pkg::ADDR_W-1:0] paddr = '0;
   logic [31:0]       pwdata = '0;
   logic [31:0]       prdata;
   logic              pready;

   pcm_scoreboard sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_req = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int cycle_count = 0;

   ms_adpcm_nibble_decoder_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_channel         (req_channel),
      .req_predictor_index (req_predictor_index),
      .req_initial_step    (req_initial_step),
      .req_older_sample    (req_older_sample),
      .req_newer_sample    (req_newer_sample),
      .req_data_byte       (req_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_pcm_sample      (rsp_pcm_sample),
      .rsp_out_channel     (rsp_out_channel),
      .rsp_last            (rsp_last),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side: check each transfer, then decide ready for the next cycle
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         sb.check_sample(rsp_pcm_sample, rsp_out_channel, rsp_last);
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_item(input msadpcm_pkg::item_type it);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_mode            <= it.mode;
      req_channel         <= it.channel;
      req_predictor_index <= it.predictor_index;
      req_initial_step    <= it.initial_step;
      req_older_sample    <= it.older_sample;
      req_newer_sample    <= it.newer_sample;
      req_data_byte       <= it.data_byte;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.take_item(it);
   endtask

   task automatic csr_write(input int idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= msadpcm_pkg::ADDR_W'(idx * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      sb.write_reg(idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic msadpcm_pkg::item_type noise_item();
      msadpcm_pkg::item_type it;
      it.mode            = 1'($urandom);
      it.channel         = 1'($urandom);
      it.predictor_index = 8'($urandom);
      it.initial_step    = 16'($urandom);
      it.older_sample    = 16'($urandom);
      it.newer_sample    = 16'($urandom);
      it.data_byte       = 8'($urandom);
      return it;
   endfunction

   function automatic msadpcm_pkg::item_type header_item(input logic ch, input int idx,
                                                         input int step, input int older,
                                                         input int newer);
      msadpcm_pkg::item_type it;
      it = noise_item();
      it.mode            = msadpcm_pkg::MODE_HEADER;
      it.channel         = ch;
      it.predictor_index = idx[7:0];
      it.initial_step    = step[15:0];
      it.older_sample    = older[15:0];
      it.newer_sample    = newer[15:0];
      return it;
   endfunction

   function automatic msadpcm_pkg::item_type data_item(input logic [7:0] b);
      msadpcm_pkg::item_type it;
      it = noise_item();
      it.mode      = msadpcm_pkg::MODE_DATA;
      it.data_byte = b;
      return it;
   endfunction

   function automatic int rand_sample();
      if ($urandom_range(1) == 0) return int'(16'($urandom)) - 32768 * 0;
      return int'($urandom_range(8000)) - 4000;
   endfunction

   function automatic msadpcm_pkg::item_type rand_header(input logic ch);
      int idx;
      int step;
      idx  = ($urandom_range(9) < 7) ? int'($urandom_range(7)) : int'($urandom_range(255));
      step = ($urandom_range(9) < 7) ? int'($urandom_range(2000, 16)) : int'($urandom);
      return header_item(ch, idx, step, rand_sample(), rand_sample());
   endfunction

   function automatic logic [31:0] rand_pair();
      int a;
      int b;
      if ($urandom_range(1) == 0) return $urandom;
      a = int'($urandom_range(1024)) - 512;
      b = int'($urandom_range(1024)) - 512;
      return {b[15:0], a[15:0]};
   endfunction

   // mostly headers followed by a run of data bytes, some stray items between
   task automatic run_random(input int n_items, input bit with_hold);
      int sent;
      bit held;
      int k;
      sent = 0;
      held = 0;
      while (sent < n_items) begin
         if (with_hold && !held && sent >= 60) begin
            hold_req = hold_req + 1;
            held = 1;
         end
         if ($urandom_range(99) < 10) begin
            send_item(noise_item());
            sent++;
         end else begin
            if ($urandom_range(9) != 0) begin
               send_item(rand_header(1'b0));
               sent++;
            end
            if ($urandom_range(9) != 0) begin
               send_item(rand_header(1'b1));
               sent++;
            end
            k = $urandom_range(12, 1);
            repeat (k) begin
               send_item(data_item(8'($urandom)));
               sent++;
            end
         end
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // decode from the all-zero reset state before any header
      send_item(data_item(8'h00));
      send_item(data_item(8'h7F));
      send_item(header_item(1'b0, 0, 16, -32768, 32767));
      send_item(header_item(1'b1, 1, 32767, 32767, 32767));
      send_item(data_item(8'h77));
      send_item(data_item(8'h88));
      // negative step size used as given
      send_item(header_item(1'b0, 2, -32768, 0, 0));
      send_item(data_item(8'h80));
      send_item(header_item(1'b1, 3, -1, -32768, -32768));
      send_item(data_item(8'h0F));
      send_item(data_item(8'hF8));
      // small negative product truncates toward zero
      send_item(header_item(1'b0, 4, 32767, 1, -1));
      send_item(data_item(8'h81));
      send_item(header_item(1'b1, 5, 1000, 12345, -23456));
      send_item(header_item(1'b0, 6, 200, -100, 300));
      send_item(data_item(8'hF1));
      // out-of-range predictor keeps the previous coefficients
      send_item(header_item(1'b0, 7, 300, 500, -500));
      send_item(header_item(1'b1, 255, 40, -7, 9));
      send_item(data_item(8'h3C));
      wait_idle();

      csr_write(int'(msadpcm_pkg::CSR_CUSTOM_COUNT), 32'd7);
      csr_write(REG_PAIR_BASE + 0, 32'h8000_8000);
      csr_write(REG_PAIR_BASE + 1, 32'h7FFF_7FFF);
      csr_write(REG_PAIR_BASE + 2, 32'hFFFF_FFFF);
      csr_write(REG_PAIR_BASE + 3, 32'h0000_0000);
      for (int i = 4; i < PAIR_REGS; i++) csr_write(REG_PAIR_BASE + i, rand_pair());

      send_item(header_item(1'b0, 0, 16, -32768, -32768));
      send_item(header_item(1'b1, 1, 16, 32767, -32768));
      send_item(data_item(8'h44));
      send_item(header_item(1'b0, 6, 500, 1234, -4321));
      send_item(data_item(8'h9E));
      send_item(header_item(1'b1, 7, 64, 100, 200));
      send_item(data_item(8'h5A));
      wait_idle();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               csr_write(int'(msadpcm_pkg::CSR_CUSTOM_COUNT), 32'd0);
               for (int i = 0; i < PAIR_REGS; i++) csr_write(REG_PAIR_BASE + i, 32'h0);
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
            1: begin
               csr_write(int'(msadpcm_pkg::CSR_CUSTOM_COUNT), 32'd7);
               for (int i = 0; i < PAIR_REGS; i++) csr_write(REG_PAIR_BASE + i, rand_pair());
               send_idle_pct = 53;
               recv_idle_pct = 0;
            end
            2: begin
               csr_write(int'(msadpcm_pkg::CSR_CUSTOM_COUNT), 32'd3);
               csr_write(REG_PAIR_BASE + 0, 32'hFFFF_FFFF);
               csr_write(REG_PAIR_BASE + 1, 32'h8000_8000);
               csr_write(REG_PAIR_BASE + 2, 32'h7FFF_7FFF);
               for (int i = 3; i < PAIR_REGS; i++) csr_write(REG_PAIR_BASE + i, rand_pair());
               send_idle_pct = 0;
               recv_idle_pct = 53;
            end
            default: begin
               csr_write(int'(msadpcm_pkg::CSR_CUSTOM_COUNT), 32'd5);
               for (int i = 0; i < PAIR_REGS; i++) csr_write(REG_PAIR_BASE + i, rand_pair());
               send_idle_pct = 7;
               recv_idle_pct = 7;
            end
         endcase
         run_random(PHASE_ITEMS, p == 0);
         wait_idle();
      end

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/msadpcm_pkg.sv
rtl/ms_adpcm_nibble_decoder_top.sv
bench/ms_adpcm_nibble_decoder_top_test.sv
